// ===== rtl/dpt_pkg.sv =====
// shared types, constants and codes for the discovery peer table
package dpt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int NAME_BYTES  = 32;

    localparam int IDX_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
    localparam int NAME_LEN_W = 5;
    localparam int ADDR_W     = 32;
    localparam int TIME_W     = 64;
    localparam int DLEN_W     = 9;
    localparam int TAG_W      = 32;
    localparam int CLAIM_W    = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [TAG_W-1:0]   REPLY_MAGIC        = 32'h5253_444D;
    localparam logic [DLEN_W-1:0]  REPLY_HEADER_BYTES = 9'd8;
    localparam logic [CLAIM_W-1:0] NAME_MAX           = CLAIM_W'(NAME_BYTES - 1);
    localparam logic [CNT_W-1:0]   DEPTH_COUNT        = CNT_W'(TABLE_DEPTH);

    localparam logic [TIME_W-1:0] QUERY_INTERVAL_RESET = 64'd1000000000;
    localparam logic [TIME_W-1:0] EXPIRE_AGE_RESET     = 64'd6000000000;
    localparam logic [TIME_W-1:0] IDLE_AGE_RESET       = 64'd3000000000;

    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPIRE_AGE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_AGE       = 2'd2;

    typedef enum logic [1:0] {
        OP_REPLY      = 2'd0,
        OP_TICK       = 2'd1,
        OP_IDLE_CHECK = 2'd2,
        OP_READ       = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STS_NOT_REPLY = 3'd0,
        STS_INSERTED  = 3'd1,
        STS_REFRESHED = 3'd2,
        STS_TOO_SHORT = 3'd3,
        STS_BAD_MAGIC = 3'd4,
        STS_FULL      = 3'd5,
        STS_CLOSED    = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_LAST,
        RD_REQ
    } rd_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SRCH_END,
        S_SWP_RD,
        S_SWP_CMP,
        S_SWP_MOVE,
        S_READ_WAIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic    load;
        logic    status_en;
        status_t status_code;
        logic    tick_update;
        logic    idle_update;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    idx_inc;
        logic    note_match;
        logic    wr_refresh;
        logic    wr_insert;
        logic    wr_move;
        logic    grab_read;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic is_open;
        logic short_len;
        logic bad_magic;
        logic read_in_range;
        logic idx_done;
        logic match;
        logic found;
        logic full;
        logic aged;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/dpt_ctrl.sv =====
// controller state machine for the discovery peer table
module dpt_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  dpt_pkg::sts_t sts,
    output dpt_pkg::cmd_t cmd
);

    dpt_pkg::state_t state_reg;
    dpt_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dpt_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dpt_pkg::S_IDLE: begin
                if (s_valid) state_next = dpt_pkg::S_DECODE;
            end
            dpt_pkg::S_DECODE: begin
                case (sts.op)
                    dpt_pkg::OP_REPLY: begin
                        if (!sts.is_open || sts.short_len || sts.bad_magic) begin
                            state_next = dpt_pkg::S_DONE;
                        end else begin
                            state_next = dpt_pkg::S_SRCH_RD;
                        end
                    end
                    dpt_pkg::OP_TICK:       state_next = dpt_pkg::S_SWP_RD;
                    dpt_pkg::OP_IDLE_CHECK: state_next = dpt_pkg::S_DONE;
                    dpt_pkg::OP_READ: begin
                        state_next = sts.read_in_range ? dpt_pkg::S_READ_WAIT
                                                       : dpt_pkg::S_DONE;
                    end
                    default: state_next = dpt_pkg::S_DONE;
                endcase
            end
            dpt_pkg::S_SRCH_RD: begin
                state_next = sts.idx_done ? dpt_pkg::S_SRCH_END : dpt_pkg::S_SRCH_CMP;
            end
            dpt_pkg::S_SRCH_CMP:  state_next = dpt_pkg::S_SRCH_RD;
            dpt_pkg::S_SRCH_END:  state_next = dpt_pkg::S_DONE;
            dpt_pkg::S_SWP_RD: begin
                state_next = sts.idx_done ? dpt_pkg::S_DONE : dpt_pkg::S_SWP_CMP;
            end
            dpt_pkg::S_SWP_CMP: begin
                state_next = sts.aged ? dpt_pkg::S_SWP_MOVE : dpt_pkg::S_SWP_RD;
            end
            dpt_pkg::S_SWP_MOVE:  state_next = dpt_pkg::S_SWP_RD;
            dpt_pkg::S_READ_WAIT: state_next = dpt_pkg::S_DONE;
            dpt_pkg::S_DONE: begin
                if (sts.out_free) state_next = dpt_pkg::S_IDLE;
            end
            default: state_next = dpt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd             = '0;
        cmd.status_code = dpt_pkg::STS_NOT_REPLY;
        cmd.rd_sel      = dpt_pkg::RD_IDX;
        s_ready         = 1'b0;
        case (state_reg)
            dpt_pkg::S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            dpt_pkg::S_DECODE: begin
                case (sts.op)
                    dpt_pkg::OP_REPLY: begin
                        if (!sts.is_open) begin
                            cmd.status_en   = 1'b1;
                            cmd.status_code = dpt_pkg::STS_CLOSED;
                        end else if (sts.short_len) begin
                            cmd.status_en   = 1'b1;
                            cmd.status_code = dpt_pkg::STS_TOO_SHORT;
                        end else if (sts.bad_magic) begin
                            cmd.status_en   = 1'b1;
                            cmd.status_code = dpt_pkg::STS_BAD_MAGIC;
                        end
                    end
                    dpt_pkg::OP_TICK:       cmd.tick_update = 1'b1;
                    dpt_pkg::OP_IDLE_CHECK: cmd.idle_update = 1'b1;
                    dpt_pkg::OP_READ: begin
                        cmd.rd_en  = sts.read_in_range;
                        cmd.rd_sel = dpt_pkg::RD_REQ;
                    end
                    default: ;
                endcase
            end
            dpt_pkg::S_SRCH_RD: begin
                cmd.rd_en  = !sts.idx_done;
                cmd.rd_sel = dpt_pkg::RD_IDX;
            end
            dpt_pkg::S_SRCH_CMP: begin
                cmd.note_match = sts.match;
                cmd.idx_inc    = 1'b1;
            end
            dpt_pkg::S_SRCH_END: begin
                cmd.status_en = 1'b1;
                if (sts.found) begin
                    cmd.wr_refresh  = 1'b1;
                    cmd.status_code = dpt_pkg::STS_REFRESHED;
                end else if (sts.full) begin
                    cmd.status_code = dpt_pkg::STS_FULL;
                end else begin
                    cmd.wr_insert   = 1'b1;
                    cmd.status_code = dpt_pkg::STS_INSERTED;
                end
            end
            dpt_pkg::S_SWP_RD: begin
                cmd.rd_en  = !sts.idx_done;
                cmd.rd_sel = dpt_pkg::RD_IDX;
            end
            dpt_pkg::S_SWP_CMP: begin
                // aged entry: fetch the last one to fill the gap
                if (sts.aged) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = dpt_pkg::RD_LAST;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            dpt_pkg::S_SWP_MOVE:  cmd.wr_move   = 1'b1;
            dpt_pkg::S_READ_WAIT: cmd.grab_read = 1'b1;
            dpt_pkg::S_DONE:      cmd.out_load  = sts.out_free;
            default: ;
        endcase
    end

endmodule

// ===== rtl/dpt_datapath.sv =====
// datapath: item registers, entry memory, table state and result registers
module dpt_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  dpt_pkg::cmd_t                  cmd,
    output dpt_pkg::sts_t                  sts,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dpt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dpt_pkg::TIME_W-1:0]     cfg_data,
    input  logic [1:0]                     s_op,
    input  logic [dpt_pkg::ADDR_W-1:0]     s_peer_address,
    input  logic [dpt_pkg::TIME_W-1:0]     s_now_time,
    input  logic [dpt_pkg::DLEN_W-1:0]     s_datagram_length,
    input  logic [dpt_pkg::TAG_W-1:0]      s_reply_tag,
    input  logic [dpt_pkg::CLAIM_W-1:0]    s_claimed_name_len,
    input  logic [dpt_pkg::IDX_W-1:0]      s_read_index,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [2:0]                     m_status,
    output logic [dpt_pkg::IDX_W-1:0]      m_slot,
    output logic [dpt_pkg::NAME_LEN_W-1:0] m_name_len,
    output logic                           m_send_query,
    output logic [dpt_pkg::CNT_W-1:0]      m_removed,
    output logic [dpt_pkg::CNT_W-1:0]      m_entry_count,
    output logic [dpt_pkg::ADDR_W-1:0]     m_read_address,
    output logic [dpt_pkg::TIME_W-1:0]     m_read_last_seen,
    output logic                           m_read_valid,
    output logic                           m_is_open
);

    // configuration
    logic [dpt_pkg::TIME_W-1:0] query_interval_reg;
    logic [dpt_pkg::TIME_W-1:0] expire_age_reg;
    logic [dpt_pkg::TIME_W-1:0] idle_age_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            query_interval_reg <= dpt_pkg::QUERY_INTERVAL_RESET;
            expire_age_reg     <= dpt_pkg::EXPIRE_AGE_RESET;
            idle_age_reg       <= dpt_pkg::IDLE_AGE_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == dpt_pkg::CFG_QUERY_INTERVAL) query_interval_reg <= cfg_data;
            if (cfg_index == dpt_pkg::CFG_EXPIRE_AGE)     expire_age_reg     <= cfg_data;
            if (cfg_index == dpt_pkg::CFG_IDLE_AGE)       idle_age_reg       <= cfg_data;
        end
    end

    // latched input beat
    logic [1:0]                  op_reg;
    logic [dpt_pkg::ADDR_W-1:0]  addr_reg;
    logic [dpt_pkg::TIME_W-1:0]  now_reg;
    logic [dpt_pkg::DLEN_W-1:0]  dlen_reg;
    logic [dpt_pkg::TAG_W-1:0]   tag_reg;
    logic [dpt_pkg::CLAIM_W-1:0] claim_reg;
    logic [dpt_pkg::IDX_W-1:0]   ridx_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= s_op;
            addr_reg  <= s_peer_address;
            now_reg   <= s_now_time;
            dlen_reg  <= s_datagram_length;
            tag_reg   <= s_reply_tag;
            claim_reg <= s_claimed_name_len;
            ridx_reg  <= s_read_index;
        end
    end

    // table state
    logic [dpt_pkg::CNT_W-1:0]  count_reg;
    logic                       open_reg;
    logic [dpt_pkg::TIME_W-1:0] last_query_reg;
    logic [dpt_pkg::TIME_W-1:0] last_tick_reg;
    logic [dpt_pkg::CNT_W-1:0]  idx_reg;
    logic                       found_reg;
    logic [dpt_pkg::IDX_W-1:0]  slot_reg;

    // entry memory
    logic [dpt_pkg::ADDR_W-1:0] mem_addr [dpt_pkg::TABLE_DEPTH];
    logic [dpt_pkg::TIME_W-1:0] mem_seen [dpt_pkg::TABLE_DEPTH];
    logic [dpt_pkg::ADDR_W-1:0] rd_addr_reg;
    logic [dpt_pkg::TIME_W-1:0] rd_seen_reg;

    logic [dpt_pkg::IDX_W-1:0]  rd_idx;
    logic [dpt_pkg::CNT_W-1:0]  last_cnt;
    logic [dpt_pkg::IDX_W-1:0]  wr_idx;
    logic                       wr_addr_en;
    logic                       wr_seen_en;
    logic [dpt_pkg::ADDR_W-1:0] wr_addr_data;
    logic [dpt_pkg::TIME_W-1:0] wr_seen_data;

    assign last_cnt = count_reg - dpt_pkg::CNT_W'(1);

    always_comb begin
        case (cmd.rd_sel)
            dpt_pkg::RD_IDX:  rd_idx = idx_reg[dpt_pkg::IDX_W-1:0];
            dpt_pkg::RD_LAST: rd_idx = last_cnt[dpt_pkg::IDX_W-1:0];
            dpt_pkg::RD_REQ:  rd_idx = ridx_reg;
            default:          rd_idx = idx_reg[dpt_pkg::IDX_W-1:0];
        endcase
    end

    always_comb begin
        wr_addr_en   = cmd.wr_insert | cmd.wr_move;
        wr_seen_en   = cmd.wr_insert | cmd.wr_move | cmd.wr_refresh;
        wr_idx       = slot_reg;
        wr_addr_data = addr_reg;
        wr_seen_data = now_reg;
        if (cmd.wr_insert) begin
            wr_idx = count_reg[dpt_pkg::IDX_W-1:0];
        end else if (cmd.wr_move) begin
            wr_idx       = idx_reg[dpt_pkg::IDX_W-1:0];
            wr_addr_data = rd_addr_reg;
            wr_seen_data = rd_seen_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_addr_en) mem_addr[wr_idx] <= wr_addr_data;
        if (wr_seen_en) mem_seen[wr_idx] <= wr_seen_data;
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_addr_reg <= mem_addr[rd_idx];
            rd_seen_reg <= mem_seen[rd_idx];
        end
    end

    // tick and idle decisions
    logic [dpt_pkg::TIME_W-1:0] lq_eff;
    logic                       query_due;
    logic                       idle_expired;
    logic [dpt_pkg::TIME_W-1:0] since_seen;

    assign lq_eff       = open_reg ? last_query_reg : '0;
    assign query_due    = (now_reg - lq_eff) > query_interval_reg;
    assign idle_expired = open_reg && ((now_reg - last_tick_reg) > idle_age_reg);
    assign since_seen   = now_reg - rd_seen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            open_reg       <= 1'b0;
            last_query_reg <= '0;
            last_tick_reg  <= '0;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
        end else begin
            if (cmd.load) begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            if (cmd.idx_inc) idx_reg <= idx_reg + dpt_pkg::CNT_W'(1);
            if (cmd.note_match) begin
                found_reg <= 1'b1;
            end
            if (cmd.tick_update) begin
                open_reg      <= 1'b1;
                last_tick_reg <= now_reg;
                if (query_due) begin
                    last_query_reg <= now_reg;
                end else if (!open_reg) begin
                    last_query_reg <= '0;
                end
            end
            if (cmd.idle_update && idle_expired) begin
                open_reg  <= 1'b0;
                count_reg <= '0;
            end
            if (cmd.wr_insert) count_reg <= count_reg + dpt_pkg::CNT_W'(1);
            if (cmd.wr_move)   count_reg <= last_cnt;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.note_match) slot_reg <= idx_reg[dpt_pkg::IDX_W-1:0];
    end

    // name length clamp
    logic [dpt_pkg::DLEN_W-1:0]  avail;
    logic [dpt_pkg::CLAIM_W-1:0] avail_ext;
    logic [dpt_pkg::CLAIM_W-1:0] nlen_a;
    logic [dpt_pkg::CLAIM_W-1:0] nlen_b;

    assign avail     = dlen_reg - dpt_pkg::REPLY_HEADER_BYTES;
    assign avail_ext = dpt_pkg::CLAIM_W'(avail);
    assign nlen_a    = (claim_reg > avail_ext) ? avail_ext : claim_reg;
    assign nlen_b    = (nlen_a > dpt_pkg::NAME_MAX) ? dpt_pkg::NAME_MAX : nlen_a;

    // result being built
    dpt_pkg::status_t              res_status_reg;
    logic [dpt_pkg::IDX_W-1:0]      res_slot_reg;
    logic [dpt_pkg::NAME_LEN_W-1:0] res_name_len_reg;
    logic                           res_send_query_reg;
    logic [dpt_pkg::CNT_W-1:0]      res_removed_reg;
    logic [dpt_pkg::ADDR_W-1:0]     res_read_address_reg;
    logic [dpt_pkg::TIME_W-1:0]     res_read_last_seen_reg;
    logic                           res_read_valid_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            res_status_reg         <= dpt_pkg::STS_NOT_REPLY;
            res_slot_reg           <= '0;
            res_name_len_reg       <= '0;
            res_send_query_reg     <= 1'b0;
            res_removed_reg        <= '0;
            res_read_address_reg   <= '0;
            res_read_last_seen_reg <= '0;
            res_read_valid_reg     <= 1'b0;
        end else begin
            if (cmd.status_en) res_status_reg <= cmd.status_code;
            if (cmd.wr_refresh) begin
                res_slot_reg     <= slot_reg;
                res_name_len_reg <= nlen_b[dpt_pkg::NAME_LEN_W-1:0];
            end
            if (cmd.wr_insert) begin
                res_slot_reg     <= count_reg[dpt_pkg::IDX_W-1:0];
                res_name_len_reg <= nlen_b[dpt_pkg::NAME_LEN_W-1:0];
            end
            if (cmd.tick_update) res_send_query_reg <= query_due;
            if (cmd.wr_move) res_removed_reg <= res_removed_reg + dpt_pkg::CNT_W'(1);
            if (cmd.grab_read) begin
                res_read_address_reg   <= rd_addr_reg;
                res_read_last_seen_reg <= rd_seen_reg;
                res_read_valid_reg     <= 1'b1;
            end
        end
    end

    // output register
    logic                           m_valid_reg;
    dpt_pkg::status_t               out_status_reg;
    logic [dpt_pkg::IDX_W-1:0]      out_slot_reg;
    logic [dpt_pkg::NAME_LEN_W-1:0] out_name_len_reg;
    logic                           out_send_query_reg;
    logic [dpt_pkg::CNT_W-1:0]      out_removed_reg;
    logic [dpt_pkg::CNT_W-1:0]      out_count_reg;
    logic [dpt_pkg::ADDR_W-1:0]     out_read_address_reg;
    logic [dpt_pkg::TIME_W-1:0]     out_read_last_seen_reg;
    logic                           out_read_valid_reg;
    logic                           out_open_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_status_reg         <= res_status_reg;
            out_slot_reg           <= res_slot_reg;
            out_name_len_reg       <= res_name_len_reg;
            out_send_query_reg     <= res_send_query_reg;
            out_removed_reg        <= res_removed_reg;
            out_count_reg          <= count_reg;
            out_read_address_reg   <= res_read_address_reg;
            out_read_last_seen_reg <= res_read_last_seen_reg;
            out_read_valid_reg     <= res_read_valid_reg;
            out_open_reg           <= open_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = out_status_reg;
    assign m_slot           = out_slot_reg;
    assign m_name_len       = out_name_len_reg;
    assign m_send_query     = out_send_query_reg;
    assign m_removed        = out_removed_reg;
    assign m_entry_count    = out_count_reg;
    assign m_read_address   = out_read_address_reg;
    assign m_read_last_seen = out_read_last_seen_reg;
    assign m_read_valid     = out_read_valid_reg;
    assign m_is_open        = out_open_reg;

    // status toward the controller
    always_comb begin
        sts.op            = dpt_pkg::op_t'(op_reg);
        sts.is_open       = open_reg;
        sts.short_len     = dlen_reg < dpt_pkg::REPLY_HEADER_BYTES;
        sts.bad_magic     = tag_reg != dpt_pkg::REPLY_MAGIC;
        sts.read_in_range = dpt_pkg::CNT_W'(ridx_reg) < count_reg;
        sts.idx_done      = idx_reg >= count_reg;
        sts.match         = rd_addr_reg == addr_reg;
        sts.found         = found_reg;
        sts.full          = count_reg >= dpt_pkg::DEPTH_COUNT;
        sts.aged          = since_seen > expire_age_reg;
        sts.out_free      = !m_valid_reg || m_ready;
    end

endmodule

// ===== rtl/discovery_peer_table_with_aging.sv =====
// Discovery peer table with aging: up to 16 peers keyed by IPv4 address, each with a
// last-seen time, held in a single-port-write, single-port-read entry memory with a
// registered read. One beat in gives one result beat out; items are worked one at a
// time. A reply walks the valid entries, reading and then comparing each one; a reply
// turned away before the search skips the walk. A tick sweeps the table and fills the
// place of each removed entry with the last one. An idle check goes straight to the
// result, and a read skips the memory read when the index is at or above the entry
// count. A finished result waits while the result side holds off the one before. The
// next beat is taken as soon as the result is parked in the output register.
// Configuration writes are always ready and must be issued while no item is in flight.
// Entry memory has no reset; only the valid count decides which entries are live.
module discovery_peer_table_with_aging (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dpt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dpt_pkg::TIME_W-1:0]     cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_op,
    input  logic [dpt_pkg::ADDR_W-1:0]     s_peer_address,
    input  logic [dpt_pkg::TIME_W-1:0]     s_now_time,
    input  logic [dpt_pkg::DLEN_W-1:0]     s_datagram_length,
    input  logic [dpt_pkg::TAG_W-1:0]      s_reply_tag,
    input  logic [dpt_pkg::CLAIM_W-1:0]    s_claimed_name_len,
    input  logic [dpt_pkg::IDX_W-1:0]      s_read_index,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [2:0]                     m_status,
    output logic [dpt_pkg::IDX_W-1:0]      m_slot,
    output logic [dpt_pkg::NAME_LEN_W-1:0] m_name_len,
    output logic                           m_send_query,
    output logic [dpt_pkg::CNT_W-1:0]      m_removed,
    output logic [dpt_pkg::CNT_W-1:0]      m_entry_count,
    output logic [dpt_pkg::ADDR_W-1:0]     m_read_address,
    output logic [dpt_pkg::TIME_W-1:0]     m_read_last_seen,
    output logic                           m_read_valid,
    output logic                           m_is_open
);

    dpt_pkg::cmd_t cmd;
    dpt_pkg::sts_t sts;

    dpt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    dpt_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_op               (s_op),
        .s_peer_address     (s_peer_address),
        .s_now_time         (s_now_time),
        .s_datagram_length  (s_datagram_length),
        .s_reply_tag        (s_reply_tag),
        .s_claimed_name_len (s_claimed_name_len),
        .s_read_index       (s_read_index),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_slot             (m_slot),
        .m_name_len         (m_name_len),
        .m_send_query       (m_send_query),
        .m_removed          (m_removed),
        .m_entry_count      (m_entry_count),
        .m_read_address     (m_read_address),
        .m_read_last_seen   (m_read_last_seen),
        .m_read_valid       (m_read_valid),
        .m_is_open          (m_is_open)
    );

endmodule

// ===== sim/tb_top.sv =====
// testbench for the discovery peer table: directed and random items checked against a predictor
module tb_top;
    import dpt_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int N_SCRIPT    = 23;
    localparam int N_PLAN      = 6;
    localparam logic [TIME_W-1:0] T_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        op_t                op;
        logic [ADDR_W-1:0]  addr;
        logic [TIME_W-1:0]  now;
        logic [DLEN_W-1:0]  dlen;
        logic [TAG_W-1:0]   tag;
        logic [CLAIM_W-1:0] claimed;
        logic [IDX_W-1:0]   ridx;
    } peer_req_t;

    typedef struct packed {
        status_t               status;
        logic [IDX_W-1:0]      slot;
        logic [NAME_LEN_W-1:0] name_len;
        logic                  send_query;
        logic [CNT_W-1:0]      removed;
        logic [CNT_W-1:0]      entry_count;
        logic [ADDR_W-1:0]     read_address;
        logic [TIME_W-1:0]     read_last_seen;
        logic                  read_valid;
        logic                  is_open;
    } response_t;

    // rows with typed = 1 carry status, count and open state known by inspection
    typedef struct packed {
        peer_req_t        req;
        logic             typed;
        status_t          st;
        logic [CNT_W-1:0] cnt;
        logic             opened;
    } script_row_t;

    typedef struct packed {
        logic [TIME_W-1:0] q;
        logic [TIME_W-1:0] e;
        logic [TIME_W-1:0] i;
        logic              rand_lim;
        logic [TIME_W-1:0] start;
        logic [31:0]       step;
        logic [15:0]       items;
        logic              calm;
    } phase_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [TIME_W-1:0]     cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_op = '0;
    logic [ADDR_W-1:0]     s_peer_address = '0;
    logic [TIME_W-1:0]     s_now_time = '0;
    logic [DLEN_W-1:0]     s_datagram_length = '0;
    logic [TAG_W-1:0]      s_reply_tag = '0;
    logic [CLAIM_W-1:0]    s_claimed_name_len = '0;
    logic [IDX_W-1:0]      s_read_index = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [2:0]            m_status;
    logic [IDX_W-1:0]      m_slot;
    logic [NAME_LEN_W-1:0] m_name_len;
    logic                  m_send_query;
    logic [CNT_W-1:0]      m_removed;
    logic [CNT_W-1:0]      m_entry_count;
    logic [ADDR_W-1:0]     m_read_address;
    logic [TIME_W-1:0]     m_read_last_seen;
    logic                  m_read_valid;
    logic                  m_is_open;

    // predictor state
    logic [TIME_W-1:0] lim_query  = QUERY_INTERVAL_RESET;
    logic [TIME_W-1:0] lim_expire = EXPIRE_AGE_RESET;
    logic [TIME_W-1:0] lim_idle   = IDLE_AGE_RESET;
    logic [ADDR_W-1:0] peer_addr [TABLE_DEPTH];
    logic [TIME_W-1:0] peer_seen [TABLE_DEPTH];
    int unsigned       peer_count = 0;
    logic              table_up = 1'b0;
    logic [TIME_W-1:0] query_mark = '0;
    logic [TIME_W-1:0] tick_mark = '0;

    response_t         response_fifo [$];
    response_t         want_beat;
    int unsigned       mismatches = 0;
    int unsigned       beats_seen = 0;
    int unsigned       quiet_cycles = 0;
    logic              steady = 1'b0;
    logic [TIME_W-1:0] clock_ns = '0;
    logic [ADDR_W-1:0] known_peers [20];
    script_row_t       script [N_SCRIPT];
    phase_t            plan [N_PLAN];

    discovery_peer_table_with_aging i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_op               (s_op),
        .s_peer_address     (s_peer_address),
        .s_now_time         (s_now_time),
        .s_datagram_length  (s_datagram_length),
        .s_reply_tag        (s_reply_tag),
        .s_claimed_name_len (s_claimed_name_len),
        .s_read_index       (s_read_index),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_slot             (m_slot),
        .m_name_len         (m_name_len),
        .m_send_query       (m_send_query),
        .m_removed          (m_removed),
        .m_entry_count      (m_entry_count),
        .m_read_address     (m_read_address),
        .m_read_last_seen   (m_read_last_seen),
        .m_read_valid       (m_read_valid),
        .m_is_open          (m_is_open)
    );

    always #6 aclk = ~aclk;

    function automatic response_t table_response(input peer_req_t rq);
        response_t   r;
        int unsigned nlen;
        int unsigned room;
        int unsigned hit_slot;
        int unsigned idx;
        int unsigned gone;
        logic        hit;
        r = '0;
        case (rq.op)
            OP_REPLY: begin
                if (!table_up) begin
                    r.status = STS_CLOSED;
                end else if (rq.dlen < REPLY_HEADER_BYTES) begin
                    r.status = STS_TOO_SHORT;
                end else if (rq.tag != REPLY_MAGIC) begin
                    r.status = STS_BAD_MAGIC;
                end else begin
                    room = rq.dlen;
                    room = room - 8;
                    nlen = rq.claimed;
                    if (nlen > room) nlen = room;
                    if (nlen > NAME_BYTES - 1) nlen = NAME_BYTES - 1;
                    hit = 1'b0;
                    hit_slot = 0;
                    for (idx = 0; idx < peer_count; idx++) begin
                        if (peer_addr[idx] == rq.addr) begin
                            hit = 1'b1;
                            hit_slot = idx;
                        end
                    end
                    if (hit) begin
                        r.status = STS_REFRESHED;
                    end else if (peer_count >= TABLE_DEPTH) begin
                        r.status = STS_FULL;
                    end else begin
                        hit_slot = peer_count;
                        peer_count++;
                        peer_addr[hit_slot] = rq.addr;
                        r.status = STS_INSERTED;
                    end
                    if (r.status != STS_FULL) begin
                        peer_seen[hit_slot] = rq.now;
                        r.slot = IDX_W'(hit_slot);
                        r.name_len = NAME_LEN_W'(nlen);
                    end
                end
            end
            OP_TICK: begin
                gone = 0;
                if (!table_up) begin
                    table_up = 1'b1;
                    query_mark = '0;
                end
                tick_mark = rq.now;
                if (rq.now - query_mark > lim_query) begin
                    r.send_query = 1'b1;
                    query_mark = rq.now;
                end
                // a removed entry is replaced by the last one, which is checked next
                idx = 0;
                while (idx < peer_count) begin
                    if (rq.now - peer_seen[idx] > lim_expire) begin
                        peer_addr[idx] = peer_addr[peer_count-1];
                        peer_seen[idx] = peer_seen[peer_count-1];
                        peer_count--;
                        gone++;
                    end else begin
                        idx++;
                    end
                end
                r.removed = CNT_W'(gone);
            end
            OP_IDLE_CHECK: begin
                if (table_up && rq.now - tick_mark > lim_idle) begin
                    table_up = 1'b0;
                    peer_count = 0;
                end
            end
            default: begin
                if (rq.ridx < peer_count) begin
                    r.read_address = peer_addr[rq.ridx];
                    r.read_last_seen = peer_seen[rq.ridx];
                    r.read_valid = 1'b1;
                end
            end
        endcase
        r.entry_count = CNT_W'(peer_count);
        r.is_open = table_up;
        return r;
    endfunction

    function automatic peer_req_t draw_request();
        peer_req_t   rq;
        int unsigned pick;
        rq.op = OP_READ;
        rq.addr = $urandom;
        rq.now = clock_ns;
        rq.dlen = DLEN_W'($urandom_range(256));
        rq.tag = $urandom;
        rq.claimed = CLAIM_W'($urandom);
        rq.ridx = IDX_W'($urandom);
        // occasional time jump anywhere in the 64-bit range
        if ($urandom_range(99) < 4) rq.now = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 45) begin
            rq.op = OP_REPLY;
            if ($urandom_range(99) < 85) rq.addr = known_peers[$urandom_range(19)];
            pick = $urandom_range(99);
            if (pick < 80) begin
                rq.tag = REPLY_MAGIC;
                if ($urandom_range(99) < 85) rq.dlen = DLEN_W'($urandom_range(40, 8));
                else rq.dlen = DLEN_W'($urandom_range(256, 8));
                if ($urandom_range(1) == 1) rq.claimed = CLAIM_W'($urandom_range(40));
            end else if (pick < 90) begin
                rq.dlen = DLEN_W'($urandom_range(7));
            end else begin
                rq.dlen = DLEN_W'($urandom_range(256, 8));
                rq.tag = REPLY_MAGIC ^ (32'd1 << $urandom_range(31));
            end
        end else if (pick < 65) begin
            rq.op = OP_TICK;
        end else if (pick < 75) begin
            rq.op = OP_IDLE_CHECK;
        end else if (peer_count > 0 && $urandom_range(99) < 60) begin
            rq.ridx = IDX_W'($urandom_range(peer_count - 1));
        end
        return rq;
    endfunction

    task automatic note_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] exp_val);
        $display("mismatch beat %0d %s: got %0h expected %0h", beats_seen, field, got, exp_val);
        mismatches++;
    endtask

    task automatic push_item(input peer_req_t rq, input logic pinned, input status_t st,
                             input logic [CNT_W-1:0] cnt, input logic opened);
        response_t want;
        while (!steady && $urandom_range(99) < 17) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= rq.op;
        s_peer_address <= rq.addr;
        s_now_time <= rq.now;
        s_datagram_length <= rq.dlen;
        s_reply_tag <= rq.tag;
        s_claimed_name_len <= rq.claimed;
        s_read_index <= rq.ridx;
        do @(negedge aclk); while (!s_ready);
        want = table_response(rq);
        if (pinned) begin
            want.status = st;
            want.entry_count = cnt;
            want.is_open = opened;
        end
        response_fifo.push_back(want);
        @(posedge aclk);
    endtask

    task automatic set_limits(input logic [63:0] q_ns, input logic [63:0] e_ns,
                              input logic [63:0] i_ns);
        for (int k = 0; k < 3; k++) begin
            case (k)
                0: begin
                    cfg_index <= CFG_QUERY_INTERVAL;
                    cfg_data <= q_ns;
                end
                1: begin
                    cfg_index <= CFG_EXPIRE_AGE;
                    cfg_data <= e_ns;
                end
                default: begin
                    cfg_index <= CFG_IDLE_AGE;
                    cfg_data <= i_ns;
                end
            endcase
            cfg_valid <= 1'b1;
            do @(negedge aclk); while (!cfg_ready);
            case (cfg_index)
                CFG_QUERY_INTERVAL: lim_query = cfg_data;
                CFG_EXPIRE_AGE: lim_expire = cfg_data;
                default: lim_idle = cfg_data;
            endcase
            @(posedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 17);
    end

    // beats are checked mid-cycle, where the handshake for the next edge is settled
    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            beats_seen++;
            if (response_fifo.size() == 0) begin
                note_mismatch("unexpected beat", m_status, 0);
            end else begin
                want_beat = response_fifo.pop_front();
                if (m_status !== want_beat.status)
                    note_mismatch("status", m_status, want_beat.status);
                if (m_slot !== want_beat.slot)
                    note_mismatch("slot", m_slot, want_beat.slot);
                if (m_name_len !== want_beat.name_len)
                    note_mismatch("name_len", m_name_len, want_beat.name_len);
                if (m_send_query !== want_beat.send_query)
                    note_mismatch("send_query", m_send_query, want_beat.send_query);
                if (m_removed !== want_beat.removed)
                    note_mismatch("removed", m_removed, want_beat.removed);
                if (m_entry_count !== want_beat.entry_count)
                    note_mismatch("entry_count", m_entry_count, want_beat.entry_count);
                if (m_read_address !== want_beat.read_address)
                    note_mismatch("read_address", m_read_address, want_beat.read_address);
                if (m_read_last_seen !== want_beat.read_last_seen)
                    note_mismatch("read_last_seen", m_read_last_seen, want_beat.read_last_seen);
                if (m_read_valid !== want_beat.read_valid)
                    note_mismatch("read_valid", m_read_valid, want_beat.read_valid);
                if (m_is_open !== want_beat.is_open)
                    note_mismatch("is_open", m_is_open, want_beat.is_open);
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        logic [63:0] q_ns;
        logic [63:0] e_ns;
        logic [63:0] i_ns;
        script = '{
            '{'{OP_REPLY, 32'h0A00_0001, 64'd1000, 9'd64, REPLY_MAGIC, 16'd4, 4'd0},
              1'b1, STS_CLOSED, 5'd0, 1'b0},
            '{'{OP_READ, 32'h0, 64'd0, 9'd0, 32'h0, 16'd0, 4'd0},
              1'b1, STS_NOT_REPLY, 5'd0, 1'b0},
            '{'{OP_IDLE_CHECK, 32'h0, T_MAX, 9'd0, 32'h0, 16'd0, 4'd0},
              1'b1, STS_NOT_REPLY, 5'd0, 1'b0},
            '{'{OP_TICK, 32'h0, 64'd5_000_000_000, 9'd0, 32'h0, 16'd0, 4'd0},
              1'b0, STS_NOT_REPLY, 5'd0, 1'b0},
            '{'{OP_REPLY, 32'h0A00_0002, 64'd5_000_000_000, 9'd0, REPLY_MAGIC, 16'd0, 4'd0},
              1'b1, STS_TOO_SHORT, 5'd0, 1'b1},
            '{'{OP_REPLY, 32'h0A00_0002, 64'd5_000_000_000, 9'd7, REPLY_MAGIC, 16'd0, 4'd0},
              1'b1, STS_TOO_SHORT, 5'd0, 1'b1},
            '{'{OP_REPLY, 32'h0A00_0002, 64'd5_000_000_000, 9'd8, 32'h0, 16'd0, 4'd0},
              1'b1, STS_BAD_MAGIC, 5'd0, 1'b1},
            '{'{OP_REPLY, 32'h0A00_0002, 64'd5_000_000_000, 9'd8, 32'hFFFF_FFFF, 16'd0, 4'd0},
              1'b1, STS_BAD_MAGIC, 5'd0, 1'b1},
            '{'{OP_REPLY, 32'h0, 64'd5_000_000_000, 9'd8, REPLY_MAGIC, 16'hFFFF, 4'd0},
              1'b0, STS_NOT_REPLY, 5'd0, 1'b0},
            '{'{OP_REPLY, 32'hFFFF_FFFF, 64'd6_000_000_000, 9'd256, REPLY_MAGIC, 16'hFFFF,
                4'd0}, 1'b0, STS_NOT_REPLY, 5'd0, 1'b0},
            '{'{OP_REPLY, 32'h0, 64'd7_000_000_000, 9'd20, REPLY_MAGIC, 16'd5, 4'd0},
              1'b0, STS_NOT_REPLY, 5'd0, 1'b0},
            '{'{OP_REPLY, 32'h0A00_0001, 64'd8_000_000_000, 9'd39, REPLY_MAGIC, 16'd40, 4'd0},
              1'b0, STS_NOT_REPLY, 5'd0, 1'b0},
            '{'{OP_REPLY, 32'hC0A8_0001, 64'd9_000_000_000, 9'd12, REPLY_MAGIC, 16'd9, 4'd0},
              1'b0, STS_NOT_REPLY, 5'd0, 1'b0},
            '{'{OP_READ, 32'h0, 64'd0, 9'd0, 32'h0, 16'd0, 4'd3},
              1'b0, STS_NOT_REPLY, 5'd0, 1'b0},
            '{'{OP_READ, 32'h0, 64'd0, 9'd0, 32'h0, 16'd0, 4'd15},
              1'b1, STS_NOT_REPLY, 5'd4, 1'b1},
            '{'{OP_TICK, 32'h0, 64'd12_000_000_001, 9'd0, 32'h0, 16'd0, 4'd0},
              1'b0, STS_NOT_REPLY, 5'd0, 1'b0},
            '{'{OP_TICK, 32'h0, 64'd13_000_000_001, 9'd0, 32'h0, 16'd0, 4'd0},
              1'b0, STS_NOT_REPLY, 5'd0, 1'b0},
            '{'{OP_IDLE_CHECK, 32'h0, 64'd16_000_000_001, 9'd0, 32'h0, 16'd0, 4'd0},
              1'b0, STS_NOT_REPLY, 5'd0, 1'b0},
            '{'{OP_IDLE_CHECK, 32'h0, 64'd16_000_000_002, 9'd0, 32'h0, 16'd0, 4'd0},
              1'b1, STS_NOT_REPLY, 5'd0, 1'b0},
            '{'{OP_TICK, 32'h0, T_MAX, 9'd0, 32'h0, 16'd0, 4'd0},
              1'b0, STS_NOT_REPLY, 5'd0, 1'b0},
            '{'{OP_REPLY, 32'h7F00_0001, T_MAX, 9'd9, REPLY_MAGIC, 16'd1, 4'd0},
              1'b0, STS_NOT_REPLY, 5'd0, 1'b0},
            '{'{OP_TICK, 32'h0, 64'd6_000_000_000, 9'd0, 32'h0, 16'd0, 4'd0},
              1'b0, STS_NOT_REPLY, 5'd0, 1'b0},
            '{'{OP_READ, 32'h0, 64'd0, 9'd0, 32'h0, 16'd0, 4'd0},
              1'b1, STS_NOT_REPLY, 5'd0, 1'b1}
        };
        // scaled-down limits, the extremes, random limits and the reset limits again
        plan = '{
            '{64'd1000, 64'd5000, 64'd4000, 1'b0, 64'd0, 32'd300, 16'd230, 1'b0},
            '{64'd0, T_MAX, T_MAX, 1'b0, 64'd100, 32'd50, 16'd230, 1'b1},
            '{64'd0, 64'd0, 64'd0, 1'b0, 64'hFFFF_FFFF_FFFF_FF00, 32'd3, 16'd200, 1'b0},
            '{64'd0, 64'd0, 64'd0, 1'b1, 64'd0, 32'hFFFF_FFFF, 16'd230, 1'b0},
            '{QUERY_INTERVAL_RESET, EXPIRE_AGE_RESET, IDLE_AGE_RESET, 1'b0,
              64'hFFFF_FFFF_0000_0000, 32'd400_000_000, 16'd230, 1'b0},
            '{T_MAX, 64'd1, 64'd2, 1'b0, 64'd7, 32'd3, 16'd230, 1'b0}
        };
        foreach (known_peers[k]) known_peers[k] = $urandom;
        known_peers[0] = 32'h0;
        known_peers[1] = 32'hFFFF_FFFF;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[n])
            push_item(script[n].req, script[n].typed, script[n].st, script[n].cnt,
                      script[n].opened);

        foreach (plan[p]) begin
            s_valid <= 1'b0;
            wait (response_fifo.size() == 0);
            @(posedge aclk);
            if (plan[p].rand_lim) begin
                q_ns = {$urandom, $urandom};
                e_ns = {$urandom, $urandom};
                i_ns = {$urandom, $urandom};
            end else begin
                q_ns = plan[p].q;
                e_ns = plan[p].e;
                i_ns = plan[p].i;
            end
            set_limits(q_ns, e_ns, i_ns);
            steady = plan[p].calm;
            clock_ns = plan[p].start;
            repeat (plan[p].items) begin
                clock_ns = clock_ns + $urandom_range(plan[p].step);
                push_item(draw_request(), 1'b0, STS_NOT_REPLY, '0, 1'b0);
            end
        end

        s_valid <= 1'b0;
        wait (response_fifo.size() == 0);
        repeat (40) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== discovery_peer_table_with_aging.f =====
rtl/dpt_pkg.sv
rtl/dpt_ctrl.sv
rtl/dpt_datapath.sv
rtl/discovery_peer_table_with_aging.sv
sim/tb_top.sv
